FILE: rtl/stereo_mid_side_imager_core_assert.svh
// Assertion macros shared by the stereo mid/side imager RTL.
`ifndef STEREO_MID_SIDE_IMAGER_CORE_ASSERT_SVH
`define STEREO_MID_SIDE_IMAGER_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SMSI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SMSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/smsi_pkg.sv
// Shared constants and types for the stereo mid/side imager.
package smsi_pkg;

  // Default widths
  localparam int SMSI_SAMPLE_BITS = 24;
  localparam int SMSI_COEF_BITS   = 32;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_B0   = 3'd0,
    CFG_B1   = 3'd1,
    CFG_B2   = 3'd2,
    CFG_A1   = 3'd3,
    CFG_A2   = 3'd4,
    CFG_ROT  = 3'd5,
    CFG_GAIN = 3'd6,
    CFG_MODE = 3'd7
  } smsi_cfg_idx_t;

  // Register values after reset, in full 32-bit Q formats
  localparam logic [31:0] RST_B0    = 32'h0400_0000;  // unity in Q6.26
  localparam logic [31:0] RST_ZERO  = 32'h0000_0000;
  localparam logic [31:0] RST_COS   = 32'h4000_0000;  // unity in Q2.30
  localparam logic [31:0] RST_GAIN  = 32'h0400_0000;  // unity in Q6.26
  localparam logic [1:0]  RST_MODE  = 2'b01;

  // Mode bits
  localparam int MODE_ENABLE = 0;
  localparam int MODE_SOLO   = 1;

endpackage

FILE: rtl/stereo_mid_side_imager_core.sv
// Stereo mid/side imager: side biquad, mid/side rotation, channel gains, peak meters.
//
// Takes one stereo pair per input transaction and returns one result transaction.
// With processing enabled the sequencer steps from ST_B0 through ST_FIN after the
// pair is accepted; ST_FIN loads the result into the output register and the next
// pair can be accepted once the sequencer is back in ST_IDLE. A single 32x32 signed
// multiplier runs eleven products in turn (three feed-forward and two feedback taps
// of the side biquad, four rotation products, two channel gains) under a step
// sequencer; the following step takes each product into an accumulator, a delay or an
// output sample in the cycle after it leaves the multiplier. In bypass the sequencer
// goes from acceptance straight to ST_FIN. The input side stalls from acceptance until
// the result moves into the output register; if the consumer still stalls the previous
// result, the final step waits and the input stays stalled for those extra cycles. The
// output register then holds the result while the next pair is worked on.
// Configuration writes are taken every cycle (cfg_ready is always high) and
// must only be issued while no pair is in flight.
`include "stereo_mid_side_imager_core_assert.svh"

module stereo_mid_side_imager_core
  import smsi_pkg::*;
#(
  parameter int SAMPLE_BITS = SMSI_SAMPLE_BITS,
  parameter int COEF_BITS   = SMSI_COEF_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [SAMPLE_BITS-1:0] in_right_in,
  input  logic                          in_block_last,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out,
  output logic        [SAMPLE_BITS-2:0] out_peak_in_left,
  output logic        [SAMPLE_BITS-2:0] out_peak_in_right,
  output logic        [SAMPLE_BITS-2:0] out_peak_out_left,
  output logic        [SAMPLE_BITS-2:0] out_peak_out_right,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [63:0]                   cfg_data
);

  localparam int CoefPad = 32 - COEF_BITS;
  localparam int MsUp    = (SAMPLE_BITS <= 24) ? 24 - SAMPLE_BITS : 0;
  localparam int MsDn    = (SAMPLE_BITS > 24) ? SAMPLE_BITS - 24 : 0;
  localparam logic signed [33:0] MsHalf = (34'sd1 <<< MsDn) >>> 1;
  localparam int OutShift = 51 - SAMPLE_BITS;
  localparam int PkBits  = SAMPLE_BITS - 1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_B0, ST_B1, ST_YS, ST_A1, ST_A2, ST_DLY, ST_YSN, ST_MSN,
    ST_YC, ST_NS, ST_RND, ST_AB, ST_GL, ST_GR, ST_OR, ST_FIN
  } state_t;

  // Round half up, then arithmetic shift right
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                  input int n);
    logic signed [63:0] half;
    half = (64'sd1 <<< n) >>> 1;
    return (v + half) >>> n;
  endfunction

  // Clamp to a signed range of the given width
  function automatic logic signed [63:0] sat_s(input logic signed [63:0] v,
                                                input int bits);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -(64'sd1 <<< (bits - 1));
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // Magnitude of a sample, most negative code clipped to full scale
  function automatic logic [PkBits-1:0] mag(input logic signed [SAMPLE_BITS-1:0] v);
    logic [SAMPLE_BITS-1:0] neg;
    neg = ~v + {{(SAMPLE_BITS-1){1'b0}}, 1'b1};
    if (!v[SAMPLE_BITS-1]) begin
      return v[PkBits-1:0];
    end else if (neg[SAMPLE_BITS-1]) begin
      return {PkBits{1'b1}};
    end
    return neg[PkBits-1:0];
  endfunction

  // Configuration registers
  logic [COEF_BITS-1:0] b0_r, b1_r, b2_r, a1_r, a2_r, cos_r, sin_r, gl_r, gr_r;
  logic [1:0]           mode_r;

  // Control and datapath registers
  state_t                        state_r;
  logic                          last_r;
  logic signed [25:0]            mid_r, side_r;
  logic signed [27:0]            ys_r;
  logic signed [63:0]            prod_r, acc_r;
  logic signed [47:0]            acc2_r, d1_r, d2_r;
  logic signed [31:0]            nm_r, ns_r, a_r, b_r;
  logic signed [SAMPLE_BITS-1:0] ol_r, or_r;
  logic [PkBits-1:0]             pin_l_r, pin_r_r, pout_l_r, pout_r_r;

  // Output register
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_l_r, out_r_r;
  logic [PkBits-1:0]             opin_l_r, opin_r_r, opout_l_r, opout_r_r;

  // Combinational helpers
  logic signed [31:0] c_b0, c_b1, c_b2, c_a1, c_a2, c_cos, c_sin, c_gl, c_gr;
  logic signed [31:0] mult_a, mult_b;
  logic signed [33:0] ms_sum, ds_sum, ms_up, ds_up;
  logic signed [25:0] mid_nxt, side_nxt;
  logic [PkBits-1:0]  mag_il, mag_ir, mag_ol, mag_or;
  logic [PkBits-1:0]  pout_l_nxt, pout_r_nxt;
  logic               in_fire, out_free;

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Widen coefficients to Q6.26 / Q2.30 at 32 bits
  assign c_b0  = 32'(b0_r) << CoefPad;
  assign c_b1  = 32'(b1_r) << CoefPad;
  assign c_b2  = 32'(b2_r) << CoefPad;
  assign c_a1  = 32'(a1_r) << CoefPad;
  assign c_a2  = 32'(a2_r) << CoefPad;
  assign c_cos = 32'(cos_r) << CoefPad;
  assign c_sin = 32'(sin_r) << CoefPad;
  assign c_gl  = 32'(gl_r) << CoefPad;
  assign c_gr  = 32'(gr_r) << CoefPad;

  // Encode to mid and side at 24 fraction bits
  always_comb begin
    ms_sum   = 34'(in_left_in) + 34'(in_right_in);
    ds_sum   = 34'(in_left_in) - 34'(in_right_in);
    ms_up    = ms_sum <<< MsUp;
    ds_up    = ds_sum <<< MsUp;
    mid_nxt  = 26'((ms_up + MsHalf) >>> MsDn);
    side_nxt = 26'((ds_up + MsHalf) >>> MsDn);
  end

  // Select multiplier operands per step
  always_comb begin
    mult_a = '0;
    mult_b = '0;
    unique case (state_r)
      ST_B0:   begin mult_a = 32'(side_r); mult_b = c_b0;  end
      ST_B1:   begin mult_a = 32'(side_r); mult_b = c_b1;  end
      ST_YS:   begin mult_a = 32'(side_r); mult_b = c_b2;  end
      ST_A1:   begin mult_a = 32'(ys_r);   mult_b = c_a1;  end
      ST_A2:   begin mult_a = 32'(ys_r);   mult_b = c_a2;  end
      ST_DLY:  begin mult_a = 32'(mid_r);  mult_b = c_cos; end
      ST_YSN:  begin mult_a = 32'(ys_r);   mult_b = c_sin; end
      ST_MSN:  begin mult_a = 32'(mid_r);  mult_b = c_sin; end
      ST_YC:   begin mult_a = 32'(ys_r);   mult_b = c_cos; end
      ST_GL:   begin mult_a = a_r;         mult_b = c_gl;  end
      ST_GR:   begin mult_a = b_r;         mult_b = c_gr;  end
      default: begin mult_a = '0;          mult_b = '0;    end
    endcase
  end

  // Peak meter updates
  always_comb begin
    mag_il     = mag(in_left_in);
    mag_ir     = mag(in_right_in);
    mag_ol     = mag(ol_r);
    mag_or     = mag(or_r);
    pout_l_nxt = (mag_ol > pout_l_r) ? mag_ol : pout_l_r;
    pout_r_nxt = (mag_or > pout_r_r) ? mag_or : pout_r_r;
  end

  // Sequencer, datapath, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      b0_r        <= RST_B0[COEF_BITS-1:0];
      b1_r        <= RST_ZERO[COEF_BITS-1:0];
      b2_r        <= RST_ZERO[COEF_BITS-1:0];
      a1_r        <= RST_ZERO[COEF_BITS-1:0];
      a2_r        <= RST_ZERO[COEF_BITS-1:0];
      cos_r       <= RST_COS[COEF_BITS-1:0];
      sin_r       <= RST_ZERO[COEF_BITS-1:0];
      gl_r        <= RST_GAIN[COEF_BITS-1:0];
      gr_r        <= RST_GAIN[COEF_BITS-1:0];
      mode_r      <= RST_MODE;
      d1_r        <= '0;
      d2_r        <= '0;
      pin_l_r     <= '0;
      pin_r_r     <= '0;
      pout_l_r    <= '0;
      pout_r_r    <= '0;
    end else begin
      // Shared multiplier, one product per cycle
      prod_r <= 64'(mult_a) * 64'(mult_b);

      // Configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (smsi_cfg_idx_t'(cfg_index))
          CFG_B0:   b0_r   <= cfg_data[COEF_BITS-1:0];
          CFG_B1:   b1_r   <= cfg_data[COEF_BITS-1:0];
          CFG_B2:   b2_r   <= cfg_data[COEF_BITS-1:0];
          CFG_A1:   a1_r   <= cfg_data[COEF_BITS-1:0];
          CFG_A2:   a2_r   <= cfg_data[COEF_BITS-1:0];
          CFG_ROT: begin
            cos_r <= cfg_data[32 +: COEF_BITS];
            sin_r <= cfg_data[0 +: COEF_BITS];
          end
          CFG_GAIN: begin
            gl_r <= cfg_data[32 +: COEF_BITS];
            gr_r <= cfg_data[0 +: COEF_BITS];
          end
          CFG_MODE: mode_r <= cfg_data[1:0];
        endcase
      end

      // Drop the result once the consumer takes it, unless the final step reloads it
      if (out_valid_r && !out_stall && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            last_r  <= in_block_last;
            mid_r   <= mid_nxt;
            side_r  <= side_nxt;
            ol_r    <= in_left_in;
            or_r    <= in_right_in;
            pin_l_r <= (mag_il > pin_l_r) ? mag_il : pin_l_r;
            pin_r_r <= (mag_ir > pin_r_r) ? mag_ir : pin_r_r;
            state_r <= mode_r[MODE_ENABLE] ? ST_B0 : ST_FIN;
          end
        end
        ST_B0: state_r <= ST_B1;
        ST_B1: begin
          // First delay sum
          acc_r   <= sat_s(rnd_shr(prod_r, 14) + 64'(d1_r), 48);
          state_r <= ST_YS;
        end
        ST_YS: begin
          // Side filter output, hold b1 term
          ys_r    <= 28'(sat_s(rnd_shr(acc_r, 12), 28));
          acc_r   <= rnd_shr(prod_r, 14);
          state_r <= ST_A1;
        end
        ST_A1: begin
          acc2_r  <= 48'(rnd_shr(prod_r, 14));
          state_r <= ST_A2;
        end
        ST_A2: begin
          acc_r   <= acc_r - rnd_shr(prod_r, 14);
          state_r <= ST_DLY;
        end
        ST_DLY: begin
          // Advance both delays
          d1_r    <= 48'(sat_s(acc_r + 64'(d2_r), 48));
          d2_r    <= 48'(sat_s(64'(acc2_r) - rnd_shr(prod_r, 14), 48));
          state_r <= ST_YSN;
        end
        ST_YSN: begin
          acc_r   <= prod_r;
          state_r <= ST_MSN;
        end
        ST_MSN: begin
          acc_r   <= acc_r - prod_r;
          state_r <= ST_YC;
        end
        ST_YC: begin
          nm_r    <= 32'(rnd_shr(acc_r, 30));
          acc_r   <= prod_r;
          state_r <= ST_NS;
        end
        ST_NS: begin
          acc_r   <= acc_r + prod_r;
          state_r <= ST_RND;
        end
        ST_RND: begin
          ns_r    <= 32'(rnd_shr(acc_r, 30));
          state_r <= ST_AB;
        end
        ST_AB: begin
          // Decode, or route side to both channels in solo
          if (mode_r[MODE_SOLO]) begin
            a_r <= ns_r;
            b_r <= ns_r;
          end else begin
            a_r <= nm_r + ns_r;
            b_r <= nm_r - ns_r;
          end
          state_r <= ST_GL;
        end
        ST_GL: state_r <= ST_GR;
        ST_GR: begin
          ol_r    <= SAMPLE_BITS'(sat_s(rnd_shr(prod_r, OutShift), SAMPLE_BITS));
          state_r <= ST_OR;
        end
        ST_OR: begin
          or_r    <= SAMPLE_BITS'(sat_s(rnd_shr(prod_r, OutShift), SAMPLE_BITS));
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          // Load the output register when it frees up
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_l_r     <= ol_r;
            out_r_r     <= or_r;
            opin_l_r    <= pin_l_r;
            opin_r_r    <= pin_r_r;
            opout_l_r   <= pout_l_nxt;
            opout_r_r   <= pout_r_nxt;
            if (last_r) begin
              pin_l_r  <= '0;
              pin_r_r  <= '0;
              pout_l_r <= '0;
              pout_r_r <= '0;
            end else begin
              pout_l_r <= pout_l_nxt;
              pout_r_r <= pout_r_nxt;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_out       = out_l_r;
  assign out_right_out      = out_r_r;
  assign out_peak_in_left   = opin_l_r;
  assign out_peak_in_right  = opin_r_r;
  assign out_peak_out_left  = opout_l_r;
  assign out_peak_out_right = opout_r_r;

  // Accepted pair starts the sequencer
  `SMSI_ASSERT_NEXT(a_start, clk, rst_n, in_fire, state_r != ST_IDLE, "sequencer did not start on accept")
  // Biquad delays move only in the delay update step
  `SMSI_ASSERT_NEXT(a_dly_hold, clk, rst_n, state_r != ST_DLY, $stable(d1_r) && $stable(d2_r), "biquad state changed outside its step")
  // A new result only comes out of the final step
  `SMSI_ASSERT_SAME(a_out_src, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_FIN, "result loaded outside final step")

endmodule
